// ===== rtl/core/cbl_pkg.sv =====
// Shared constants, codes and types of the clipped sprite blitter.
package cbl_pkg;

    // Frame store size and largest source dimension
    localparam int FB_BYTES = 65536;
    localparam int MAX_DIM  = 1024;

    localparam int FB_AW = $clog2(FB_BYTES);
    localparam int POS_W = $clog2(MAX_DIM);

    // Fixed field widths
    localparam int DIM_W     = 11;
    localparam int COORD_W   = 16;
    localparam int PIX_W     = 8;
    localparam int RADDR_W   = 16;
    localparam int MODE_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Compare width for position against dimensions, destination sum width
    localparam int CMP_W       = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;
    localparam int DX_W        = COORD_W + 2;
    localparam int ADDR_FULL_W = 2 * DIM_W + 1;

    // Queue between classifier and memory side
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds
    localparam logic KIND_BLIT = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Mode bit positions
    localparam int MODE_FLIP_H = 0;
    localparam int MODE_FLIP_V = 1;
    localparam int MODE_TRANSP = 2;
    localparam int MODE_XOR    = 3;

    // Register reset values
    localparam logic [DIM_W-1:0] FB_WIDTH_RST  = DIM_W'(320);
    localparam logic [DIM_W-1:0] FB_HEIGHT_RST = DIM_W'(200);
    localparam logic [DIM_W-1:0] FB_PITCH_RST  = DIM_W'(320);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DEST_X     = 3'd2,
        CFG_DEST_Y     = 3'd3,
        CFG_FB_WIDTH   = 3'd4,
        CFG_FB_HEIGHT  = 3'd5,
        CFG_FB_PITCH   = 3'd6,
        CFG_MODE       = 3'd7
    } t_cfg_reg;

    // Classified job handed from the front to the memory side
    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
        logic             clipped;
        logic             transp;
        logic             xor_en;
        logic [FB_AW-1:0] addr;
    } t_job;

endpackage

// ===== rtl/core/cbl_in_if.sv =====
// Input channel: source pixel or readback request with valid/ready.
interface cbl_in_if import cbl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [PIX_W-1:0]   pixel;
    logic               first;
    logic [RADDR_W-1:0] read_address;

    modport source (output valid, kind, pixel, first, read_address, input ready);
    modport sink   (input valid, kind, pixel, first, read_address, output ready);
endinterface

// ===== rtl/core/cbl_out_if.sv =====
// Output channel: one result per item with valid/ready.
interface cbl_out_if import cbl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] read_data;
    logic             written;
    logic             clipped;

    modport source (output valid, read_data, written, clipped, input ready);
    modport sink   (input valid, read_data, written, clipped, output ready);
endinterface

// ===== rtl/core/cbl_front.sv =====
// Front end: config registers, source position, destination math and clipping.
module cbl_front import cbl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    cbl_in_if.sink               i_pix,
    output t_job                 o_job,
    output logic                 o_job_valid,
    input  logic                 i_job_ready
);

    typedef struct packed {
        logic               kind;
        logic [PIX_W-1:0]   pixel;
        logic               clipped;
        logic               transp;
        logic               xor_en;
        logic [DIM_W-1:0]   dx;
        logic [DIM_W-1:0]   dy;
        logic [RADDR_W-1:0] raddr;
    } t_f1;

    // Configuration registers
    logic [DIM_W-1:0]   r_src_width, r_src_height;
    logic [COORD_W-1:0] r_dest_x, r_dest_y;
    logic [DIM_W-1:0]   r_fb_width, r_fb_height, r_fb_pitch;
    logic [MODE_W-1:0]  r_mode;

    // Source position
    logic [POS_W-1:0] r_col, r_row;
    logic [POS_W-1:0] n_col, n_row;

    // Pipeline stages
    logic r_f1_valid, r_f2_valid;
    t_f1  r_f1, n_f1;
    t_job r_f2, n_f2;

    logic in_ready, accept, f1_adv, f2_adv;

    logic [POS_W-1:0]       col_cur, row_cur;
    logic [CMP_W-1:0]       col_x, row_x, srcw_x, srch_x, ox, oy, col_inc;
    logic [DX_W-1:0]        dx, dy;
    logic                   src_clip, dst_clip, wrap;
    logic [2*DIM_W-1:0]     prod;
    logic [ADDR_FULL_W-1:0] full_addr;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= '0;
            r_src_height <= '0;
            r_dest_x     <= '0;
            r_dest_y     <= '0;
            r_fb_width   <= FB_WIDTH_RST;
            r_fb_height  <= FB_HEIGHT_RST;
            r_fb_pitch   <= FB_PITCH_RST;
            r_mode       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[DIM_W-1:0];
                CFG_DEST_X:     r_dest_x     <= i_cfg_data[COORD_W-1:0];
                CFG_DEST_Y:     r_dest_y     <= i_cfg_data[COORD_W-1:0];
                CFG_FB_WIDTH:   r_fb_width   <= i_cfg_data[DIM_W-1:0];
                CFG_FB_HEIGHT:  r_fb_height  <= i_cfg_data[DIM_W-1:0];
                CFG_FB_PITCH:   r_fb_pitch   <= i_cfg_data[DIM_W-1:0];
                CFG_MODE:       r_mode       <= i_cfg_data[MODE_W-1:0];
            endcase
        end
    end

    // Handshake chain
    always_comb begin
        f2_adv   = r_f2_valid && i_job_ready;
        f1_adv   = r_f1_valid && (!r_f2_valid || f2_adv);
        in_ready = !r_f1_valid || f1_adv;
        accept   = i_pix.valid && in_ready;
    end

    assign i_pix.ready = in_ready;

    // Stage 1: position, mirror, destination and visible-area clip
    always_comb begin
        col_cur = i_pix.first ? '0 : r_col;
        row_cur = i_pix.first ? '0 : r_row;
        col_x   = CMP_W'(col_cur);
        row_x   = CMP_W'(row_cur);
        srcw_x  = CMP_W'(r_src_width);
        srch_x  = CMP_W'(r_src_height);

        src_clip = (col_x >= srcw_x) || (row_x >= srch_x);
        ox = r_mode[MODE_FLIP_H] ? (srcw_x - CMP_W'(1) - col_x) : col_x;
        oy = r_mode[MODE_FLIP_V] ? (srch_x - CMP_W'(1) - row_x) : row_x;
        dx = DX_W'($signed(r_dest_x)) + DX_W'(ox);
        dy = DX_W'($signed(r_dest_y)) + DX_W'(oy);
        dst_clip = dx[DX_W-1] || (dx >= DX_W'(r_fb_width)) ||
                   dy[DX_W-1] || (dy >= DX_W'(r_fb_height));

        n_f1.kind    = i_pix.kind;
        n_f1.pixel   = i_pix.pixel;
        n_f1.clipped = src_clip || dst_clip;
        n_f1.transp  = r_mode[MODE_TRANSP];
        n_f1.xor_en  = r_mode[MODE_XOR];
        n_f1.dx      = dx[DIM_W-1:0];
        n_f1.dy      = dy[DIM_W-1:0];
        n_f1.raddr   = i_pix.read_address;

        // Advance after a blit
        col_inc = col_x + CMP_W'(1);
        wrap    = (col_inc >= srcw_x) || (col_inc == CMP_W'(MAX_DIM));
        n_col   = r_col;
        n_row   = r_row;
        if (accept && (i_pix.kind == KIND_BLIT)) begin
            if (wrap) begin
                n_col = '0;
                n_row = (row_cur == POS_W'(MAX_DIM - 1)) ? '0 : row_cur + POS_W'(1);
            end else begin
                n_col = col_inc[POS_W-1:0];
                n_row = row_cur;
            end
        end
    end

    // Stage 2: byte address and memory-range clip
    always_comb begin
        prod = (2*DIM_W)'(r_f1.dy) * (2*DIM_W)'(r_fb_pitch);
        if (r_f1.kind == KIND_READ) begin
            full_addr = ADDR_FULL_W'(r_f1.raddr);
        end else begin
            full_addr = ADDR_FULL_W'(prod) + ADDR_FULL_W'(r_f1.dx);
        end
        n_f2.kind    = r_f1.kind;
        n_f2.pixel   = r_f1.pixel;
        n_f2.transp  = r_f1.transp;
        n_f2.xor_en  = r_f1.xor_en;
        n_f2.clipped = ((r_f1.kind == KIND_BLIT) && r_f1.clipped) ||
                       (full_addr >= ADDR_FULL_W'(FB_BYTES));
        n_f2.addr    = full_addr[FB_AW-1:0];
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_ready) begin
                r_f1_valid <= i_pix.valid;
            end
            if (!r_f2_valid || f2_adv) begin
                r_f2_valid <= f1_adv;
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1 <= n_f1;
        end
        if (f1_adv) begin
            r_f2 <= n_f2;
        end
    end

    assign o_job       = r_f2;
    assign o_job_valid = r_f2_valid;

    // A stalled stage keeps its item
    a_f2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f2_valid && !i_job_ready |=> r_f2_valid && $stable(r_f2))
        else $error("front stage 2 lost a stalled item");
    a_f1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_valid && !f1_adv |=> r_f1_valid && $stable(r_f1))
        else $error("front stage 1 lost a stalled item");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> r_f1_valid && r_f2_valid)
        else $error("input stalled with a free stage");

endmodule

// ===== rtl/core/cbl_queue.sv =====
// Short job queue between the front end and the memory side.
module cbl_queue import cbl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output t_job o_head,
    output logic o_head_valid,
    input  logic i_pop
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/core/cbl_back.sv =====
// Memory side: frame store, read-modify-write with forwarding, result register.
module cbl_back import cbl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job     i_head,
    input  logic     i_head_valid,
    output logic     o_pop,
    cbl_out_if.source o_res
);

    logic [PIX_W-1:0] r_mem [FB_BYTES];

    // Execute stage
    logic             r_s_valid;
    t_job             r_s_job;
    logic [PIX_W-1:0] r_rdata;
    logic             r_fwd_hit;
    logic [PIX_W-1:0] r_fwd_data;

    // Result register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_written;
    logic             r_out_clipped;

    logic             s_fire, pop, wr_en;
    logic [PIX_W-1:0] cur, wdata, res_data;

    // Flow control
    always_comb begin
        s_fire = r_s_valid && (!r_out_valid || o_res.ready);
        pop    = i_head_valid && (!r_s_valid || s_fire);
    end

    assign o_pop = pop;

    // Result and write decision
    always_comb begin
        cur      = r_fwd_hit ? r_fwd_data : r_rdata;
        wdata    = r_s_job.xor_en ? (cur ^ r_s_job.pixel) : r_s_job.pixel;
        wr_en    = 1'b0;
        res_data = '0;
        priority if (r_s_job.clipped) begin
            res_data = '0;
        end else if (r_s_job.kind == KIND_READ) begin
            res_data = cur;
        end else if (r_s_job.transp && (r_s_job.pixel == '0)) begin
            res_data = cur;
        end else begin
            res_data = wdata;
            wr_en    = s_fire;
        end
    end

    // Frame store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s_job.addr] <= wdata;
        end
        if (pop) begin
            r_rdata <= r_mem[i_head.addr];
        end
    end

    // Execute stage payload and forwarding of the write made at pop time
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s_job    <= i_head;
            r_fwd_hit  <= wr_en && (r_s_job.addr == i_head.addr);
            r_fwd_data <= wdata;
        end
        if (s_fire) begin
            r_out_data    <= res_data;
            r_out_written <= wr_en;
            r_out_clipped <= r_s_job.clipped;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_s_valid || s_fire) begin
                r_s_valid <= pop;
            end
            if (s_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.read_data = r_out_data;
    assign o_res.written   = r_out_written;
    assign o_res.clipped   = r_out_clipped;

    a_write_not_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_written |-> !r_out_clipped)
        else $error("clipped result marked written");
    a_clipped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_clipped |-> (r_out_data == '0))
        else $error("clipped result carries data");
    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid && (r_s_job.kind == KIND_READ) |-> !wr_en)
        else $error("readback wrote the frame store");

endmodule

// ===== rtl/core/clipped_sprite_blitter.sv =====
// Items pass front stages 1 and 2, the queue, the execute stage and result register.
// Throughput: one item per cycle while o_res is ready; the frame store has one write
//   and one read port; XOR read-modify-write on the last item's byte is forwarded.
// Reset (synchronous, active low) clears the pipeline, queue, source position
//   and config registers to their defaults; the frame store is not cleared.
// Top level of the clipped sprite blitter.
module clipped_sprite_blitter import cbl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    cbl_in_if.sink               i_pix,
    cbl_out_if.source            o_res
);

    t_job job, head;
    logic job_valid, full, head_valid, pop;

    // Classification front end
    cbl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_ready (!full)
    );

    // Decoupling queue
    cbl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (job_valid && !full),
        .i_job        (job),
        .o_full       (full),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    // Frame store and results
    cbl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule
